@@ rtl/core/bsmh_pkg.sv @@
// Shared types, constants and mixing functions of the byte stream hash.
`default_nettype none

package bsmh_pkg;

   localparam int WORD_W = 64;
   localparam int COUNT_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int MIX_STEPS = 6;
   localparam int STEP_W = $clog2(MIX_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_STEPS - 1);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [7:0] byte_type;

   localparam word_type GOLDEN_RATIO = 64'h9e37_79b9_7f4a_7c13;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
   } mix_words_type;

   // One queue entry: a full group to absorb, a message end, or both.
   typedef struct packed {
      logic               start;
      word_type           seed;
      logic               do_group;
      logic               do_tail;
      byte_type           byte0;
      byte_type           byte1;
      byte_type           byte2;
      logic [1:0]         tail_count;
      logic [COUNT_W-1:0] total;
   } bsmh_op_type;

   // One line of the mix network; the line index picks the word and the shift.
   function automatic mix_words_type mix_line(input mix_words_type w, input logic [3:0] line);
      mix_words_type r;
      r = w;
      case (line)
         4'd0:  r.a = (w.a - w.b - w.c) ^ (w.c >> 43);
         4'd1:  r.b = (w.b - w.c - w.a) ^ (w.a << 9);
         4'd2:  r.c = (w.c - w.a - w.b) ^ (w.b >> 8);
         4'd3:  r.a = (w.a - w.b - w.c) ^ (w.c >> 38);
         4'd4:  r.b = (w.b - w.c - w.a) ^ (w.a << 23);
         4'd5:  r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
         4'd6:  r.a = (w.a - w.b - w.c) ^ (w.c >> 35);
         4'd7:  r.b = (w.b - w.c - w.a) ^ (w.a << 49);
         4'd8:  r.c = (w.c - w.a - w.b) ^ (w.b >> 11);
         4'd9:  r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
         4'd10: r.b = (w.b - w.c - w.a) ^ (w.a << 18);
         4'd11: r.c = (w.c - w.a - w.b) ^ (w.b >> 22);
         default: r = w;
      endcase
      return r;
   endfunction

   // Two consecutive lines of the network per step.
   function automatic mix_words_type mix_pair(input mix_words_type w,
                                              input logic [STEP_W-1:0] step);
      return mix_line(mix_line(w, {step, 1'b0}), {step, 1'b1});
   endfunction

   function automatic mix_words_type group_add(input mix_words_type w, input bsmh_op_type op);
      mix_words_type r;
      r.a = w.a + {48'd0, op.byte0, 8'd0};
      r.b = w.b + {40'd0, op.byte1, 16'd0};
      r.c = w.c + {24'd0, op.byte2, 32'd0};
      return r;
   endfunction

   function automatic mix_words_type tail_add(input mix_words_type w, input bsmh_op_type op);
      mix_words_type r;
      r.a = w.a + ((op.tail_count != 2'd0) ? {56'd0, op.byte0} : 64'd0);
      r.b = w.b + ((op.tail_count == 2'd2) ? {56'd0, op.byte1} : 64'd0);
      r.c = w.c + {29'd0, op.total, 3'd0};
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsmh_ifs.sv @@
// Handshake interfaces of the request and response channels.
`default_nettype none

interface bsmh_req_if;
   import bsmh_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     has_byte;
   logic     last;
   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface bsmh_rsp_if;
   import bsmh_pkg::*;
   logic     valid;
   logic     ready;
   word_type hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsmh_front.sv @@
// Front end: takes bytes, gathers groups of three and queues mix work.
`default_nettype none

module bsmh_front (
   input  logic                 clock,
   input  logic                 reset,
   bsmh_req_if.sink             req_chan,
   input  logic                 csr_write_en,
   input  bsmh_pkg::word_type   csr_write_data,
   output logic                 push,
   output bsmh_pkg::bsmh_op_type push_op,
   input  logic                 queue_ready
);
   import bsmh_pkg::*;

   word_type           seed_ff;
   word_type           seed_hold_ff;
   logic               active_ff;
   logic               start_pend_ff;
   logic [1:0]         count_ff;
   logic [COUNT_W-1:0] total_ff;
   byte_type           held0_ff;
   byte_type           held1_ff;

   logic               fire;
   logic               effect;
   logic               grp;
   logic               start_now;
   byte_type           held0_in;
   byte_type           held1_in;
   logic [COUNT_W-1:0] total_in;

   assign req_chan.ready = queue_ready;

   always_comb begin
      fire      = req_chan.valid && req_chan.ready;
      effect    = fire && (req_chan.has_byte || req_chan.last);
      grp       = req_chan.has_byte && (count_ff == 2'd2);
      start_now = start_pend_ff || !active_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      if (req_chan.has_byte && !grp) begin
         if (count_ff[0]) begin
            held1_in = req_chan.data_byte;
         end else begin
            held0_in = req_chan.data_byte;
         end
      end
      total_in = total_ff + COUNT_W'(req_chan.has_byte);

      push_op.start      = start_now;
      push_op.seed       = active_ff ? seed_hold_ff : seed_ff;
      push_op.do_group   = grp;
      push_op.do_tail    = req_chan.last;
      push_op.byte0      = held0_in;
      push_op.byte1      = held1_in;
      push_op.byte2      = req_chan.data_byte;
      push_op.tail_count = grp ? 2'd0 : (count_ff + 2'(req_chan.has_byte));
      push_op.total      = total_in;
      push = effect && (grp || req_chan.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= '0;
         active_ff     <= 1'b0;
         start_pend_ff <= 1'b0;
         count_ff      <= 2'd0;
         total_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            seed_ff <= csr_write_data;
         end
         if (effect) begin
            if (!active_ff) begin
               seed_hold_ff <= seed_ff;
            end
            if (req_chan.last) begin
               active_ff     <= 1'b0;
               start_pend_ff <= 1'b0;
               count_ff      <= 2'd0;
               total_ff      <= '0;
            end else begin
               active_ff     <= 1'b1;
               // The start mark rides on the first queued entry of the message.
               start_pend_ff <= push ? 1'b0 : start_now;
               count_ff      <= push_op.tail_count;
               total_ff      <= total_in;
               held0_ff      <= held0_in;
               held1_ff      <= held1_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bsmh_queue.sv @@
// Short queue of mix work between the front end and the mix engine.
`default_nettype none

module bsmh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsmh_pkg::bsmh_op_type push_op,
   output logic                  push_ready,
   output logic                  pop_valid,
   output bsmh_pkg::bsmh_op_type pop_op,
   input  logic                  pop
);
   import bsmh_pkg::*;

   bsmh_op_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   fill_ff;

   logic do_push;
   logic do_pop;

   assign push_ready = (fill_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            slot_ff[wr_ptr_ff] <= push_op;
            wr_ptr_ff          <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bsmh_back.sv @@
// Mix engine: holds the three hash words, runs the mix network and drives results.
`default_nettype none

module bsmh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  bsmh_pkg::bsmh_op_type op_in,
   output logic                  op_pop,
   bsmh_rsp_if.source            rsp_chan
);
   import bsmh_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MIX, ST_TAIL} state_type;

   state_type         state_ff;
   mix_words_type     words_ff;
   logic [STEP_W-1:0] step_ff;
   logic              emit_ff;
   logic              tail_pend_ff;
   bsmh_op_type       op_ff;
   logic              rsp_valid_ff;
   word_type          rsp_hash_ff;

   mix_words_type base;
   mix_words_type stepped;
   logic          out_free;

   assign op_pop              = (state_ff == ST_IDLE) && op_valid;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;

   always_comb begin
      if (op_in.start) begin
         base.a = op_in.seed;
         base.b = op_in.seed;
         base.c = GOLDEN_RATIO;
      end else begin
         base = words_ff;
      end
      stepped  = mix_pair(words_ff, step_ff);
      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         emit_ff      <= 1'b0;
         tail_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (op_valid) begin
                  op_ff   <= op_in;
                  step_ff <= '0;
                  if (op_in.do_group) begin
                     words_ff     <= group_add(base, op_in);
                     emit_ff      <= 1'b0;
                     tail_pend_ff <= op_in.do_tail;
                  end else begin
                     words_ff     <= tail_add(base, op_in);
                     emit_ff      <= 1'b1;
                     tail_pend_ff <= 1'b0;
                  end
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: begin
               if (step_ff != LAST_STEP) begin
                  words_ff <= stepped;
                  step_ff  <= step_ff + 1'b1;
               end else if (emit_ff) begin
                  // The final step waits here until the result register is free.
                  if (out_free) begin
                     words_ff     <= stepped;
                     rsp_hash_ff  <= stepped.c;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  words_ff <= stepped;
                  state_ff <= tail_pend_ff ? ST_TAIL : ST_IDLE;
               end
            end
            ST_TAIL: begin
               words_ff     <= tail_add(words_ff, op_ff);
               emit_ff      <= 1'b1;
               tail_pend_ff <= 1'b0;
               step_ff      <= '0;
               state_ff     <= ST_MIX;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/byte_stream_mix64_hash_core.sv @@
// Top level of the byte stream 64-bit mix hash.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        data_byte[7:0], has_byte, last
//   rsp_chan  out        valid/ready        hash_value[63:0]
//   csr_*     in         write enable only  csr_write_data[63:0] = seed
//
// A byte is taken every cycle while the four-entry work queue has room.
// Each full group of three bytes costs the mix engine a load and six steps of
// two network lines; the engine pops the next entry only when idle, and a
// message end adds a tail load and six more steps before its hash appears.
// Reset is synchronous and clears all control state; a stalled response
// holds the engine only at the last step of a final mix.
`default_nettype none

module byte_stream_mix64_hash_core (
   input  logic               clock,
   input  logic               reset,
   bsmh_req_if.sink           req_chan,
   bsmh_rsp_if.source         rsp_chan,
   input  logic               csr_write_en,
   input  bsmh_pkg::word_type csr_write_data
);
   import bsmh_pkg::*;

   logic        push;
   bsmh_op_type push_op;
   logic        queue_ready;
   logic        op_valid;
   bsmh_op_type op_head;
   logic        op_pop;

   bsmh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push),
      .push_op        (push_op),
      .queue_ready    (queue_ready)
   );

   bsmh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .push_ready (queue_ready),
      .pop_valid  (op_valid),
      .pop_op     (op_head),
      .pop        (op_pop)
   );

   bsmh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_in    (op_head),
      .op_pop   (op_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ rtl/core/bsmh_checker.sv @@
// Port-level checks of the hash core and the bind that attaches them.
`default_nettype none

module bsmh_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bsmh_pkg::word_type rsp_hash
);

   // A stalled result must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash))
      else $error("response changed while stalled");

   // Reset empties the queue and the result register.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   // A hash needs at least a load and a full mix, so no response may rise within that span after reset.
   a_min_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
         && !$past(reset, 4) && !$past(reset, 5) && !$past(reset, 6)
         && !$past(reset, 7))
      else $error("response too soon after reset");

endmodule

bind byte_stream_mix64_hash_core bsmh_checker u_bsmh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.hash_value)
);

`default_nettype wire
